// ===== hdl/sdb_pkg.sv =====
// Shared constants and types for the switch debouncer.
package sdb_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int TS_WIDTH       = 48;
  localparam int CFG_WIDTH      = 24;
  localparam int APB_AW         = 4;
  localparam int APB_DW         = 32;
  localparam int IN_TDATA_W     = 56;
  localparam int OUT_TDATA_W    = 8;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 24'd50000;
  localparam logic [CFG_WIDTH-1:0] STABLE_ON_RST  = 24'd1000000;
  localparam logic [CFG_WIDTH-1:0] STABLE_OFF_RST = 24'd1000000;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_STABLE_ON  = 2'd1,
    REG_STABLE_OFF = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_time;
    logic [CFG_WIDTH-1:0] stable_on_time;
    logic [CFG_WIDTH-1:0] stable_off_time;
  } sdb_cfg_t;

endpackage

// ===== hdl/switch_debounce_with_hold_confirm.sv =====
// Top level: stream handshake, input register, config bank and debounce core.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[47:0] timestamp, tdata[48] raw_pressed
//  m_axis   | out       | tdata[0] pressed, tdata[1] confirmed
//  apb      | in/out    | 0x0 debounce_time, 0x4 stable_on_time, 0x8 stable_off_time
//
// One poll per clock while m_axis is not stalled; a poll passes from its s_axis transaction
// into the input register, then into the result register updated by the debounce core, with m_axis_tvalid.
// rst is synchronous and clears the valid flags, the core state and the config to defaults.
// m_axis stall holds the result; the input register still takes one more poll.
module switch_debounce_with_hold_confirm
  import sdb_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [47:0] timestamp, [48] raw_pressed
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] pressed, [1] confirmed
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  sdb_cfg_t            cfg;
  logic                in_valid;
  logic [TS_WIDTH-1:0] in_ts;
  logic                in_raw;
  logic                out_free;
  logic                step;
  logic                res_pressed;
  logic                res_stable;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ts  <= s_axis_tdata[TS_WIDTH-1:0];
      in_raw <= s_axis_tdata[TS_WIDTH];
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-2){1'b0}}, res_stable, res_pressed};

  sdb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdb_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ts          (in_ts),
    .raw         (in_raw),
    .cfg         (cfg),
    .res_pressed (res_pressed),
    .res_stable  (res_stable)
  );

endmodule

// ===== hdl/sdb_cfg.sv =====
// APB register bank holding the debounce and confirm times.
module sdb_cfg
  import sdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output sdb_cfg_t          cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_RST;
      cfg.stable_on_time  <= STABLE_ON_RST;
      cfg.stable_off_time <= STABLE_OFF_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DEBOUNCE:   cfg.debounce_time   <= pwdata[CFG_WIDTH-1:0];
        REG_STABLE_ON:  cfg.stable_on_time  <= pwdata[CFG_WIDTH-1:0];
        REG_STABLE_OFF: cfg.stable_off_time <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE:   prdata = APB_DW'(cfg.debounce_time);
      REG_STABLE_ON:  prdata = APB_DW'(cfg.stable_on_time);
      REG_STABLE_OFF: prdata = APB_DW'(cfg.stable_off_time);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/sdb_core.sv =====
// Debounce state, combinational update per poll, and the result register.
module sdb_core
  import sdb_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [TS_WIDTH-1:0] ts,
  input  logic                raw,
  input  sdb_cfg_t            cfg,
  output logic                res_pressed,
  output logic                res_stable
);

  logic                  started;
  logic                  last_raw;
  logic [TIME_WIDTH-1:0] raw_since;
  logic                  deb_level;
  logic [TIME_WIDTH-1:0] deb_since;
  logic                  deb_valid;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] raw_el;
  logic [TIME_WIDTH-1:0] deb_el;
  logic [CFG_WIDTH-1:0]  need;
  logic                  restart;
  logic                  deb_ok;
  logic                  level_chg;
  logic                  first_conf;
  logic                  deb_level_next;
  logic                  deb_valid_next;
  logic                  stable_next;

  assign now     = TIME_WIDTH'(ts);
  assign raw_el  = now - raw_since;
  assign deb_el  = now - deb_since;
  assign restart = !started || (raw != last_raw);

  // a restarted raw time has zero elapsed
  assign deb_ok = restart ? (cfg.debounce_time == '0)
                          : (raw_el >= TIME_WIDTH'(cfg.debounce_time));

  assign level_chg      = deb_ok && (deb_level != raw);
  assign first_conf     = deb_ok && (deb_level == raw) && !deb_valid;
  assign deb_level_next = level_chg ? raw : deb_level;
  assign deb_valid_next = deb_valid || deb_ok;
  assign need           = deb_level_next ? cfg.stable_on_time : cfg.stable_off_time;

  always_comb begin
    if (level_chg || first_conf) begin
      stable_next = (need == '0);
    end else begin
      stable_next = deb_valid && (deb_el >= TIME_WIDTH'(need));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      last_raw    <= 1'b0;
      raw_since   <= '0;
      deb_level   <= 1'b0;
      deb_since   <= '0;
      deb_valid   <= 1'b0;
      res_pressed <= 1'b0;
      res_stable  <= 1'b0;
    end else if (step) begin
      started <= 1'b1;
      if (restart) begin
        last_raw  <= raw;
        raw_since <= now;
      end
      if (level_chg || first_conf) begin
        deb_since <= now;
      end
      deb_level   <= deb_level_next;
      deb_valid   <= deb_valid_next;
      res_pressed <= deb_level_next;
      res_stable  <= stable_next;
    end
  end

  a_valid_needs_start: assert property (@(posedge clk) disable iff (rst)
    deb_valid |-> started)
    else $error("debounced time valid before first poll");

  a_step_starts: assert property (@(posedge clk) disable iff (rst)
    step |=> started)
    else $error("poll did not start the debouncer");

  a_stable_needs_valid: assert property (@(posedge clk) disable iff (rst)
    step |=> (!res_stable || deb_valid))
    else $error("stable flag without valid debounced time");

  a_level_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(deb_level))
    else $error("debounced level moved without a poll");

endmodule

// ===== tb/switch_debounce_with_hold_confirm_tb.sv =====
// Self-checking testbench for the switch debouncer: random polls, APB config, stream checks.
module switch_debounce_with_hold_confirm_tb;
  import sdb_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES = 8;
  localparam int POLLS_PER_PHASE = 66;

  typedef struct {
    logic [TS_WIDTH-1:0] ts;
    logic                raw;
  } poll_t;

  typedef struct {
    logic pressed;
    logic stable;
  } switch_level_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [47:0] timestamp, [48] raw_pressed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] pressed, [1] confirmed
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  switch_debounce_with_hold_confirm uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // predictor config and state
  logic [CFG_WIDTH-1:0] hold_need = DEBOUNCE_RST;
  logic [CFG_WIDTH-1:0] on_need = STABLE_ON_RST;
  logic [CFG_WIDTH-1:0] off_need = STABLE_OFF_RST;
  logic                 seen_first = 1'b0;
  logic                 prev_raw = 1'b0;
  logic [TW-1:0]        raw_t0 = '0;
  logic                 level = 1'b0;
  logic [TW-1:0]        level_t0 = '0;
  logic                 level_t0_ok = 1'b0;

  poll_t         pending_polls[$];
  switch_level_t expected_levels[$];

  bit          idle_on = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int          err_count = 0;
  int          cycles = 0;
  poll_t       next_poll;
  switch_level_t got_level;
  switch_level_t want_level;

  logic [TS_WIDTH-1:0] gen_ts = '0;
  logic                gen_raw = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic switch_level_t debounce_predict(logic [TS_WIDTH-1:0] ts, logic raw);
    logic [TW-1:0] now;
    logic [TW-1:0] held;
    logic [TW-1:0] lasted;
    switch_level_t r;
    now = TW'(ts);
    if (!seen_first || raw != prev_raw) begin
      prev_raw = raw;
      raw_t0 = now;
      seen_first = 1'b1;
    end
    held = now - raw_t0;
    if (held >= TW'(hold_need)) begin
      if (level != raw) begin
        level = raw;
        level_t0 = now;
        level_t0_ok = 1'b1;
      end else if (!level_t0_ok) begin
        level_t0 = now;
        level_t0_ok = 1'b1;
      end
    end
    r.pressed = level;
    r.stable = 1'b0;
    if (level_t0_ok) begin
      lasted = now - level_t0;
      r.stable = lasted >= TW'(level ? on_need : off_need);
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, switch_level_t want, switch_level_t got);
    if (err_count < 10)
      $display("MISMATCH %s: expected pressed=%0b stable=%0b, got pressed=%0b stable=%0b",
               what, want.pressed, want.stable, got.pressed, got.stable);
    err_count++;
  endfunction

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_levels.push_back(debounce_predict(s_axis_tdata[47:0], s_axis_tdata[48]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          next_poll = pending_polls.pop_front();
          s_axis_tdata <= {7'd0, next_poll.raw, next_poll.ts};
          s_axis_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0)
            src_gap <= $urandom_range(1, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_level.pressed = m_axis_tdata[0];
        got_level.stable = m_axis_tdata[1];
        if (expected_levels.size() == 0) begin
          want_level = '{1'bx, 1'bx};
          note_mismatch("unexpected transaction", want_level, got_level);
        end else begin
          want_level = expected_levels.pop_front();
          if (got_level.pressed !== want_level.pressed)
            note_mismatch("pressed", want_level, got_level);
          if (got_level.stable !== want_level.stable)
            note_mismatch("confirmed", want_level, got_level);
        end
      end
      if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0)
          sink_gap <= $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("switch_debounce_with_hold_confirm: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEBOUNCE:   hold_need = val;
      REG_STABLE_ON:  on_need = val;
      REG_STABLE_OFF: off_need = val;
      default: ;
    endcase
  endtask

  task automatic set_times(input logic [CFG_WIDTH-1:0] d, input logic [CFG_WIDTH-1:0] on_t,
                           input logic [CFG_WIDTH-1:0] off_t);
    cfg_write(REG_DEBOUNCE, d);
    cfg_write(REG_STABLE_ON, on_t);
    cfg_write(REG_STABLE_OFF, off_t);
  endtask

  task automatic add_poll(input logic [TS_WIDTH-1:0] ts, input logic raw);
    poll_t p;
    p.ts = ts;
    p.raw = raw;
    pending_polls.push_back(p);
  endtask

  // wait for the sender to empty out and every result to come back
  task automatic drain();
    while (pending_polls.size() != 0 || s_axis_tvalid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // runs of steady raw level with random steps, bounces, jumps and time wraps
  task automatic queue_polls(input int count, input int unsigned step_max);
    int unsigned run_left;
    int unsigned pick;
    int k;
    logic bounce;
    run_left = $urandom_range(1, 20);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        gen_ts = TS_WIDTH'({$urandom, $urandom});
      else if (pick < 8)
        gen_ts = {TS_WIDTH{1'b1}} - TS_WIDTH'($urandom_range(0, step_max));
      else if (pick < 16)
        gen_ts = gen_ts + TS_WIDTH'($urandom_range(0, 32'h0200_0000));
      else
        gen_ts = gen_ts + TS_WIDTH'($urandom_range(0, step_max));
      if (run_left == 0) begin
        gen_raw = ~gen_raw;
        run_left = $urandom_range(1, 20);
      end else begin
        run_left--;
      end
      bounce = ($urandom_range(0, 9) == 0);
      add_poll(gen_ts, gen_raw ^ bounce);
    end
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] d, on_t, off_t;
    int unsigned longest;
    int ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values: first latch, debounce edge, confirm edges, bounce, wrap
    add_poll(48'd0, 1'b0);
    add_poll(48'd49999, 1'b0);
    add_poll(48'd50000, 1'b0);
    add_poll(48'd1049999, 1'b0);
    add_poll(48'd1050000, 1'b0);
    add_poll(48'd1050001, 1'b1);
    add_poll(48'd1100001, 1'b1);
    add_poll(48'd2100001, 1'b1);
    add_poll(48'd2100002, 1'b0);
    add_poll(48'd2100003, 1'b1);
    add_poll(48'hFFFF_FFFF_FFFF, 1'b1);
    add_poll(48'h0000_0000_C34F, 1'b1);
    add_poll(48'd5, 1'b0);
    drain();

    // zero times: condition met at once
    set_times('0, '0, '0);
    add_poll(48'h8000_0000_0000, 1'b1);
    add_poll(48'h8000_0000_0000, 1'b0);
    add_poll(48'h8000_0000_0001, 1'b1);
    drain();

    // longest times
    set_times('1, '1, '1);
    add_poll(48'h0000_0100_0000, 1'b0);
    add_poll(48'h0000_01FF_FFFE, 1'b0);
    add_poll(48'h0000_01FF_FFFF, 1'b0);
    add_poll(48'h0000_02FF_FFFE, 1'b0);
    add_poll(48'h0000_02FF_FFFF, 1'b0);
    add_poll(48'h5555_5555_5555, 1'b1);
    add_poll(48'hAAAA_AAAA_AAAA, 1'b1);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin d = '1; on_t = '1; off_t = '1; end
        1: begin d = '0; on_t = CFG_WIDTH'($urandom_range(0, 50)); off_t = '0; end
        2: begin d = CFG_WIDTH'($urandom); on_t = CFG_WIDTH'($urandom);
                 off_t = CFG_WIDTH'($urandom); end
        default: begin
          d = CFG_WIDTH'($urandom_range(0, 40));
          on_t = CFG_WIDTH'($urandom_range(0, 300));
          off_t = CFG_WIDTH'($urandom_range(0, 300));
        end
      endcase
      set_times(d, on_t, off_t);
      longest = 32'(d);
      if (32'(on_t) > longest) longest = 32'(on_t);
      if (32'(off_t) > longest) longest = 32'(off_t);
      idle_on = (ph != NUM_PHASES - 1) && (ph % 3 != 1 || $urandom_range(0, 1) == 1);
      gen_ts = TS_WIDTH'({$urandom, $urandom});
      queue_polls(POLLS_PER_PHASE, longest / 4 + 3);
      drain();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("switch_debounce_with_hold_confirm: match");
    end else begin
      $display("switch_debounce_with_hold_confirm: mismatch");
    end
    $finish;
  end

endmodule
